// ----- hw/rtl/fvl_pkg.sv -----
// Shared types, constants and the sequencer control store for the FAT16 layout calculator.
package fvl_pkg;

  localparam int MAX_ROUNDS = 32;
  localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
  localparam int F_W        = 25;
  localparam int NEED_W     = 27;
  localparam int D_W        = 18;
  localparam int PC_W       = 4;
  localparam int DIVD_W     = 32;
  localparam int DIVS_W     = 8;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ZERO_CLUSTER = 3'd1,
    ST_TOO_SMALL    = 3'd2,
    ST_FAT_LARGE    = 3'd3,
    ST_NO_CONVERGE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_IN_WAIT,
    COND_DIV_BUSY,
    COND_OUT_BUSY,
    COND_ZERO_S,
    COND_ROUND_ERR,
    COND_F_CHANGED,
    COND_R_CHANGED,
    COND_FIN_ERR
  } cond_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CHK_S,
    ACT_ROUND,
    ACT_F_STORE,
    ACT_R_START,
    ACT_R_STORE,
    ACT_FIN,
    ACT_CNT_STORE,
    ACT_D_START,
    ACT_DCL_STORE,
    ACT_EMIT
  } act_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    act_t            act;
  } ctrl_word_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_CHK_S = 4'd1;
  localparam logic [PC_W-1:0] PC_ROUND = 4'd2;
  localparam logic [PC_W-1:0] PC_WAITF = 4'd3;
  localparam logic [PC_W-1:0] PC_FCHK  = 4'd4;
  localparam logic [PC_W-1:0] PC_WAITR = 4'd5;
  localparam logic [PC_W-1:0] PC_RCHK  = 4'd6;
  localparam logic [PC_W-1:0] PC_FIN   = 4'd7;
  localparam logic [PC_W-1:0] PC_WAITC = 4'd8;
  localparam logic [PC_W-1:0] PC_DSTRT = 4'd9;
  localparam logic [PC_W-1:0] PC_WAITD = 4'd10;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd11;
  localparam logic [PC_W-1:0] PC_BACK  = 4'd12;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIVD_W-1:0] quot;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      PC_IDLE:  w = '{COND_IN_WAIT,   PC_IDLE,  ACT_LOAD};
      PC_CHK_S: w = '{COND_ZERO_S,    PC_EMIT,  ACT_CHK_S};
      PC_ROUND: w = '{COND_ROUND_ERR, PC_EMIT,  ACT_ROUND};
      PC_WAITF: w = '{COND_DIV_BUSY,  PC_WAITF, ACT_F_STORE};
      PC_FCHK:  w = '{COND_F_CHANGED, PC_ROUND, ACT_R_START};
      PC_WAITR: w = '{COND_DIV_BUSY,  PC_WAITR, ACT_R_STORE};
      PC_RCHK:  w = '{COND_R_CHANGED, PC_ROUND, ACT_NONE};
      PC_FIN:   w = '{COND_FIN_ERR,   PC_EMIT,  ACT_FIN};
      PC_WAITC: w = '{COND_DIV_BUSY,  PC_WAITC, ACT_CNT_STORE};
      PC_DSTRT: w = '{COND_NEXT,      PC_IDLE,  ACT_D_START};
      PC_WAITD: w = '{COND_DIV_BUSY,  PC_WAITD, ACT_DCL_STORE};
      PC_EMIT:  w = '{COND_OUT_BUSY,  PC_EMIT,  ACT_EMIT};
      PC_BACK:  w = '{COND_ALWAYS,    PC_IDLE,  ACT_NONE};
      default:  w = '{COND_ALWAYS,    PC_IDLE,  ACT_NONE};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/fvl_if.sv -----
// Request and result channel interfaces for the FAT16 layout calculator.
interface fvl_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_sectors;
  logic [7:0]  clus_size;

  modport source (output valid, total_sectors, clus_size, input ready);
  modport sink (input valid, total_sectors, clus_size, output ready);
endinterface

interface fvl_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  rsvd_count;
  logic [15:0] fat_sectors;
  logic [17:0] data_start_sector;
  logic [31:0] cluster_count;
  logic [17:0] data_start_cluster;

  modport source (output valid, status, rsvd_count, fat_sectors, data_start_sector,
                  cluster_count, data_start_cluster, input ready);
  modport sink (input valid, status, rsvd_count, fat_sectors, data_start_sector,
                cluster_count, data_start_cluster, output ready);
endinterface

// ----- hw/rtl/fvl_div.sv -----
// Bit-serial restoring divider: 32-bit dividend by 8-bit divisor, one quotient bit per cycle.
module fvl_div
  import fvl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIVD_W-1:0]         quot;
  logic [DIVS_W-1:0]         rem;
  logic [$clog2(DIVD_W)-1:0] cnt;
  logic                      busy;
  logic [DIVS_W:0]           trial;
  logic                      ge;
  logic [DIVS_W:0]           diff;

  always_comb begin
    trial = {rem, quot[DIVD_W-1]};
    ge    = trial >= {1'b0, req.divisor};
    diff  = trial - {1'b0, req.divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      quot <= req.dividend;
      rem  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      quot <= {quot[DIVD_W-2:0], ge};
      cnt  <= cnt + 1'b1;
      if (cnt == $clog2(DIVD_W)'(DIVD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

// ----- hw/rtl/fat16_volume_layout_calc.sv -----
// FAT16 layout calculator: microcoded sequencer over a shared serial divider.
// Flow: a zero cluster size goes straight to the result; otherwise each iteration round makes up
// to two passes through the serial divider, for up to MAX_ROUNDS rounds, followed by two more
// passes through the divider for the final cluster counts.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: synchronous rst returns the step counter to idle and drops the result valid.
module fat16_volume_layout_calc
  import fvl_pkg::*;
(
  input logic       clk,
  input logic       rst,
  fvl_req_if.sink   req,
  fvl_res_if.source res
);

  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  ctrl_word_t         cw;
  logic               take;
  logic               go;

  logic [31:0]        t;
  logic [7:0]         s;
  logic [7:0]         r;
  logic [7:0]         prev_r;
  logic [F_W-1:0]     f;
  logic [F_W-1:0]     prev_f;
  logic [ROUND_W-1:0] round;
  status_t            st;
  logic [31:0]        cnt;
  logic [D_W-1:0]     dcl;

  logic               out_valid;
  status_t            out_status;
  logic [7:0]         out_r;
  logic [15:0]        out_f;
  logic [D_W-1:0]     out_d;
  logic [31:0]        out_cnt;
  logic [D_W-1:0]     out_dcl;

  logic [NEED_W-1:0]  need;
  logic [32:0]        num;
  logic [D_W-1:0]     d;
  logic               round_max;
  logic               too_small;
  logic               round_err;
  logic               f_large;
  logic               fin_small;
  logic               fin_err;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  fvl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    cw        = ucode_rom(pc);
    need      = NEED_W'(r) + NEED_W'({f, 1'b0}) + NEED_W'(32);
    num       = {1'b0, t} - 33'(need) + 33'({s, 8'h00}) - 33'd1;
    d         = D_W'(r) + D_W'({f[15:0], 1'b0}) + D_W'(32);
    round_max = round == ROUND_W'(MAX_ROUNDS);
    too_small = t < 32'(need);
    round_err = round_max || too_small;
    f_large   = f[F_W-1:16] != '0;
    fin_small = t < 32'(d);
    fin_err   = f_large || fin_small;

    unique case (cw.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_IN_WAIT:   take = !req.valid;
      COND_DIV_BUSY:  take = div_rsp.busy;
      COND_OUT_BUSY:  take = out_valid && !res.ready;
      COND_ZERO_S:    take = s == '0;
      COND_ROUND_ERR: take = round_err;
      COND_F_CHANGED: take = f != prev_f;
      COND_R_CHANGED: take = r != prev_r;
      COND_FIN_ERR:   take = fin_err;
      default:        take = 1'b1;
    endcase

    unique case (cw.cond) inside
      COND_IN_WAIT, COND_DIV_BUSY, COND_OUT_BUSY: go = !take;
      default:                                    go = 1'b1;
    endcase

    pc_next = take ? cw.target : pc + 1'b1;

    div_req.divisor  = s;
    div_req.start    = 1'b0;
    div_req.dividend = 32'(num[32:8]);
    unique case (cw.act)
      ACT_ROUND: begin
        div_req.start    = !round_err;
        div_req.dividend = 32'(num[32:8]);
      end
      ACT_R_START: begin
        div_req.start    = f == prev_f;
        div_req.dividend = 32'({f, 1'b0}) + 32'd32;
      end
      ACT_FIN: begin
        div_req.start    = !fin_err;
        div_req.dividend = t - 32'(d);
      end
      ACT_D_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = 32'(d);
      end
      default: begin
        div_req.start    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      case (cw.act)
        ACT_LOAD: begin
          t     <= req.total_sectors;
          s     <= req.clus_size;
          r     <= 8'd1;
          f     <= F_W'(1);
          round <= '0;
          st    <= ST_OK;
        end
        ACT_CHK_S: begin
          if (s == '0) begin
            st <= ST_ZERO_CLUSTER;
          end
        end
        ACT_ROUND: begin
          if (round_max) begin
            st <= ST_NO_CONVERGE;
          end else if (too_small) begin
            st <= ST_TOO_SMALL;
          end else begin
            prev_f <= f;
            prev_r <= r;
            round  <= round + 1'b1;
          end
        end
        ACT_F_STORE: begin
          f <= div_rsp.quot[F_W-1:0];
        end
        ACT_R_STORE: begin
          r <= (div_rsp.rem != '0) ? s - div_rsp.rem : 8'd1;
        end
        ACT_FIN: begin
          if (f_large) begin
            st <= ST_FAT_LARGE;
          end else if (fin_small) begin
            st <= ST_TOO_SMALL;
          end
        end
        ACT_CNT_STORE: begin
          cnt <= div_rsp.quot;
        end
        ACT_DCL_STORE: begin
          dcl <= div_rsp.quot[D_W-1:0];
        end
        ACT_EMIT: begin
          out_status <= st;
          if (st == ST_OK) begin
            out_r   <= r;
            out_f   <= f[15:0];
            out_d   <= d;
            out_cnt <= cnt;
            out_dcl <= dcl;
          end else begin
            out_r   <= '0;
            out_f   <= '0;
            out_d   <= '0;
            out_cnt <= '0;
            out_dcl <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && cw.act == ACT_EMIT) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign req.ready              = pc == PC_IDLE;
  assign res.valid              = out_valid;
  assign res.status             = out_status;
  assign res.rsvd_count         = out_r;
  assign res.fat_sectors        = out_f;
  assign res.data_start_sector  = out_d;
  assign res.cluster_count      = out_cnt;
  assign res.data_start_cluster = out_dcl;

endmodule

// ----- tb/fat16_volume_layout_calc_tb.sv -----
// Testbench for the FAT16 layout calculator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module fat16_volume_layout_calc_tb;
  import fvl_pkg::*;

  localparam int RUN_LIMIT   = 12_000_000;
  localparam int SETTLE_WAIT = 2500;

  typedef struct {
    logic [31:0] total;
    logic [7:0]  spc;
    status_t     status;
    logic [7:0]  reserved;
    logic [15:0] fat;
    logic [17:0] data_sector;
    logic [31:0] clusters;
    logic [17:0] data_cluster;
  } layout_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   error_count;
  int   sink_hold_cycles;
  bit   idle_enable;

  layout_t pending_layouts[$];

  fvl_req_if req_ch();
  fvl_res_if res_ch();

  fat16_volume_layout_calc u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic layout_t predict_layout(input logic [31:0] t, input logic [7:0] s);
    layout_t lay;
    longint unsigned tt, ss, r, f, need, pf, pr, rem, d;
    bit settled;
    lay.total        = t;
    lay.spc          = s;
    lay.status       = ST_OK;
    lay.reserved     = '0;
    lay.fat          = '0;
    lay.data_sector  = '0;
    lay.clusters     = '0;
    lay.data_cluster = '0;
    tt = t;
    ss = s;
    r = 1;
    f = 1;
    settled = 1'b0;
    if (ss == 0) begin
      lay.status = ST_ZERO_CLUSTER;
      return lay;
    end
    for (int rnd = 0; rnd < MAX_ROUNDS; rnd++) begin
      need = r + 2 * f + 32;
      pf = f;
      pr = r;
      if (tt < need) begin
        lay.status = ST_TOO_SMALL;
        return lay;
      end
      f = (tt - need + 256 * ss - 1) / (256 * ss);
      if (f != pf) continue;
      rem = (2 * f + 32) % ss;
      r = (rem != 0) ? ss - rem : 1;
      if (r != pr) continue;
      settled = 1'b1;
      break;
    end
    if (!settled) begin
      lay.status = ST_NO_CONVERGE;
      return lay;
    end
    if (f > 64'hFFFF) begin
      lay.status = ST_FAT_LARGE;
      return lay;
    end
    d = r + 2 * f + 32;
    if (tt < d) begin
      lay.status = ST_TOO_SMALL;
      return lay;
    end
    lay.reserved     = r[7:0];
    lay.fat          = f[15:0];
    lay.data_sector  = d[17:0];
    lay.clusters     = 32'((tt - d) / ss);
    lay.data_cluster = 18'(d / ss);
    return lay;
  endfunction

  function automatic logic [31:0] random_total_sectors();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 3000);
      default: return $urandom_range(60000, 8388608);
    endcase
  endfunction

  function automatic logic [7:0] random_cluster_size();
    case ($urandom_range(9)) inside
      0: return 8'd0;
      [1:4]: return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("ERROR @%0d: %s", cycle_count, what);
  endtask

  // Search for a request whose layout iteration the predictor reports as not converging.
  task automatic pick_stuck_request(output logic [31:0] t, output logic [7:0] s);
    layout_t probe;
    for (int i = 0; i < 100000; i++) begin
      t = $urandom >> $urandom_range(4, 31);
      s = 8'(1 << $urandom_range(0, 3));
      if ($urandom_range(3) == 0) s = 8'($urandom_range(1, 255));
      probe = predict_layout(t, s);
      if (probe.status == ST_NO_CONVERGE) return;
    end
  endtask

  task automatic send_format_request(input logic [31:0] t, input logic [7:0] s);
    if (idle_enable && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.total_sectors <= t;
    req_ch.clus_size     <= s;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    pending_layouts.push_back(predict_layout(t, s));
  endtask

  task automatic wait_all_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_layouts.size() != 0) @(posedge clk);
  endtask

  task automatic test_zero_cluster();
    send_format_request(32'd0, 8'd0);
    send_format_request(32'hFFFF_FFFF, 8'd0);
    send_format_request($urandom, 8'd0);
  endtask

  task automatic test_too_small();
    send_format_request(32'd0, 8'd1);
    send_format_request(32'd34, 8'd1);
    send_format_request(32'd34, 8'd255);
    // passes the first round, then the padded reserved area no longer fits
    send_format_request(32'd40, 8'd255);
    send_format_request(32'd1, 8'd128);
  endtask

  task automatic test_fat_too_large();
    send_format_request(32'hFFFF_FFFF, 8'd1);
    send_format_request(32'hFFFF_FFFF, 8'd255);
    send_format_request(32'h8000_0000, 8'd64);
  endtask

  task automatic test_valid_layouts();
    send_format_request(32'd16777215, 8'd255);
    send_format_request(32'd4194304, 8'd64);
    send_format_request(32'd1048576, 8'd32);
    send_format_request(32'd65536, 8'd4);
    send_format_request(32'd100000, 8'd1);
    send_format_request(32'h0FFF_FFFF, 8'd128);
    send_format_request(32'd2000, 8'd2);
    send_format_request(32'd4200000000, 8'd255);
  endtask

  task automatic test_no_convergence();
    logic [31:0] t;
    logic [7:0]  s;
    for (int i = 0; i < 3; i++) begin
      pick_stuck_request(t, s);
      send_format_request(t, s);
    end
  endtask

  task automatic test_random(input int count);
    logic [31:0] t;
    logic [7:0]  s;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5) begin
        pick_stuck_request(t, s);
      end else begin
        t = random_total_sectors();
        s = random_cluster_size();
      end
      send_format_request(t, s);
    end
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    test_random(200);
    idle_enable = 1'b1;
  endtask

  task automatic test_sink_hold();
    sink_hold_cycles = 3000;
    test_random(8);
  endtask

  task automatic test_drain_then_resume();
    wait_all_results();
    test_random(20);
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        sink_hold_cycles--;
      end else begin
        res_ch.ready <= !(idle_enable && $urandom_range(99) < 12);
      end
    end
  end

  initial begin
    layout_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_layouts.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = pending_layouts.pop_front();
          if (res_ch.status !== want.status)
            report_mismatch($sformatf("T=%0d S=%0d status got %0d want %0d",
                            want.total, want.spc, res_ch.status, want.status));
          if (res_ch.rsvd_count !== want.reserved)
            report_mismatch($sformatf("T=%0d S=%0d reserved got %0d want %0d",
                            want.total, want.spc, res_ch.rsvd_count, want.reserved));
          if (res_ch.fat_sectors !== want.fat)
            report_mismatch($sformatf("T=%0d S=%0d fat got %0d want %0d",
                            want.total, want.spc, res_ch.fat_sectors, want.fat));
          if (res_ch.data_start_sector !== want.data_sector)
            report_mismatch($sformatf("T=%0d S=%0d data sector got %0d want %0d",
                            want.total, want.spc, res_ch.data_start_sector, want.data_sector));
          if (res_ch.cluster_count !== want.clusters)
            report_mismatch($sformatf("T=%0d S=%0d clusters got %0d want %0d",
                            want.total, want.spc, res_ch.cluster_count, want.clusters));
          if (res_ch.data_start_cluster !== want.data_cluster)
            report_mismatch($sformatf("T=%0d S=%0d data cluster got %0d want %0d",
                            want.total, want.spc, res_ch.data_start_cluster, want.data_cluster));
        end
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d requests pending", cycle_count,
             pending_layouts.size());
    $display("tb: failure");
    $finish;
  end

  initial begin
    error_count      = 0;
    sink_hold_cycles = 0;
    idle_enable      = 1'b1;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.total_sectors <= '0;
    req_ch.clus_size     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_zero_cluster();
    test_too_small();
    test_fat_too_large();
    test_valid_layouts();
    test_no_convergence();
    test_random(500);
    test_sink_hold();
    test_back_to_back();
    test_drain_then_resume();
    test_random(500);

    wait_all_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (pending_layouts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_layouts.size()));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
